>>> hw/rtl/xtea_pkg.sv
// Shared types, constants and round functions for the XTEA block cipher.
// Used by xtea_stage and xtea_block_cipher; depends on nothing else.
package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RCNT_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RCNT_RST  = 32;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_ROUNDS = 3'd4
  } cfg_reg_t;

  typedef logic [3:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
  } blk_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
    mix_word = ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // One half of a Feistel round. Decryption runs the halves in reverse.
  function automatic blk_t half_round(input blk_t b, input logic second, input key_t key);
    blk_t                r;
    logic [WORD_W-1:0]   lo_term;
    logic [WORD_W-1:0]   hi_term;
    r       = b;
    lo_term = mix_word(b.v1) ^ (b.sum + key[b.sum[1:0]]);
    hi_term = mix_word(b.v0) ^ (b.sum + key[b.sum[12:11]]);
    unique case ({b.mode, second})
      2'b00: begin
        r.v0  = b.v0 + lo_term;
        r.sum = b.sum + XTEA_DELTA;
      end
      2'b01: begin
        r.v1 = b.v1 + hi_term;
      end
      2'b10: begin
        r.v1  = b.v1 - hi_term;
        r.sum = b.sum - XTEA_DELTA;
      end
      default: begin
        r.v0 = b.v0 - lo_term;
      end
    endcase
    half_round = r;
  endfunction

endpackage

>>> hw/rtl/xtea_stage.sv
// One pipeline stage of the XTEA cipher: half a Feistel round and its register.
// Depends on xtea_pkg.
module xtea_stage #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_in,
  input  xtea_pkg::blk_t                blk_in,
  input  xtea_pkg::key_t                key,
  input  logic [xtea_pkg::RCNT_W-1:0]   rounds,
  output logic                          vld_r,
  output xtea_pkg::blk_t                blk_r
);

  localparam int unsigned ROUND_IDX = STAGE_IDX / 2;
  localparam logic        SECOND    = (STAGE_IDX % 2) == 1;

  logic           active;
  xtea_pkg::blk_t blk_nxt;

  assign active = {1'b0, 8'(ROUND_IDX)} < {2'b00, rounds};

  always_comb begin
    blk_nxt = active ? xtea_pkg::half_round(blk_in, SECOND, key) : blk_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

endmodule

>>> hw/rtl/xtea_block_cipher.sv
// XTEA block cipher, pipelined with one half round per stage.
// Every block passes through every stage, whatever the round count.
// One block is accepted per cycle; a stall at the output holds the whole pipeline.
// Synchronous active-low reset empties the pipeline, clears the key to zero and
// sets the round count to 32, or to MAX_ROUNDS if that is smaller. Depends on xtea_pkg and xtea_stage.
module xtea_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [63:0]                      in_tdata,   // block_low, block_high
  input  logic                             in_tuser,   // mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [63:0]                      out_tdata,  // result_low, result_high
  input  logic                             cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]      cfg_wdata
);

  localparam int unsigned DEPTH    = 2 * MAX_ROUNDS;
  localparam int unsigned SAT      = (MAX_ROUNDS < 127) ? MAX_ROUNDS : 127;
  localparam int unsigned RND_RST  = (xtea_pkg::RCNT_RST < SAT) ? xtea_pkg::RCNT_RST : SAT;
  localparam logic [xtea_pkg::RCNT_W-1:0] SAT_RND = xtea_pkg::RCNT_W'(SAT);
  localparam logic [xtea_pkg::WORD_W-1:0] DSUM_RST =
    xtea_pkg::WORD_W'(xtea_pkg::XTEA_DELTA * RND_RST);

  xtea_pkg::key_t                   key_r;
  logic [xtea_pkg::RCNT_W-1:0]      rounds_r;
  logic [xtea_pkg::WORD_W-1:0]      dsum_r;
  logic [xtea_pkg::RCNT_W-1:0]      wr_rounds;
  logic [xtea_pkg::WORD_W-1:0]      wr_dsum;
  logic                             advance;

  logic           stg_vld [DEPTH+1];
  xtea_pkg::blk_t stg_blk [DEPTH+1];

  assign wr_rounds = (cfg_wdata[xtea_pkg::RCNT_W-1:0] > SAT_RND) ?
                     SAT_RND : cfg_wdata[xtea_pkg::RCNT_W-1:0];
  assign wr_dsum   = xtea_pkg::XTEA_DELTA *
                     {{(xtea_pkg::WORD_W-xtea_pkg::RCNT_W){1'b0}}, wr_rounds};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= xtea_pkg::RCNT_W'(RND_RST);
      dsum_r   <= DSUM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xtea_pkg::CFG_KEY0:   key_r[0] <= cfg_wdata;
        xtea_pkg::CFG_KEY1:   key_r[1] <= cfg_wdata;
        xtea_pkg::CFG_KEY2:   key_r[2] <= cfg_wdata;
        xtea_pkg::CFG_KEY3:   key_r[3] <= cfg_wdata;
        xtea_pkg::CFG_ROUNDS: begin
          rounds_r <= wr_rounds;
          dsum_r   <= wr_dsum;
        end
        default: begin
        end
      endcase
    end
  end

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = rst_n && advance;

  assign stg_vld[0] = in_tvalid;
  assign stg_blk[0] = '{mode: in_tuser,
                        v0:   in_tdata[31:0],
                        v1:   in_tdata[63:32],
                        sum:  (in_tuser ? dsum_r : '0)};

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    xtea_stage #(
      .STAGE_IDX(k)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .vld_in (stg_vld[k]),
      .blk_in (stg_blk[k]),
      .key    (key_r),
      .rounds (rounds_r),
      .vld_r  (stg_vld[k+1]),
      .blk_r  (stg_blk[k+1])
    );
  end

  assign out_tvalid = stg_vld[DEPTH];
  assign out_tdata  = {stg_blk[DEPTH].v1, stg_blk[DEPTH].v0};

  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (stg_vld[1] && stg_blk[1].mode == $past(in_tuser)))
    else $error("accepted block did not enter the first stage");

  a_rounds_sat: assert property (@(posedge clk) disable iff (!rst_n)
    rounds_r <= SAT_RND)
    else $error("round count above the built maximum");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("pipeline not empty after reset");

endmodule
